// ----- hdl/prtt_pkg.sv -----
// ----------------------------------------------------------------------------
// prtt_pkg
// Shared types and constants of the pending request table with timeout.
// ----------------------------------------------------------------------------
`default_nettype none

package prtt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned ID_W       = 32;
  localparam int unsigned CATEGORY_W = 8;
  localparam int unsigned HANDLER_W  = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned STATUS_W   = 3;

  localparam logic [AGE_W-1:0] EXPIRE_AGE_RST = 16'd120;

  // item kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_e;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [CATEGORY_W-1:0] category;
    logic [HANDLER_W-1:0]  handler;
    logic [TIME_W-1:0]     stamp;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/pending_request_table_timeout_unit.sv -----
// ----------------------------------------------------------------------------
// pending_request_table_timeout_unit
// Ordered table of outstanding requests with category replacement and timeout.
// ----------------------------------------------------------------------------
// One item at a time. After its transfer, an item is scanned over every entry
// and then waits in a done state until the output register is free, before
// the next input transfer is possible: the table lives in a single memory
// with a registered read, and the sequencer reads one entry per cycle. A fetch
// drops entries older than the programmed age and the first id match while it
// walks the table, compacting the rest in place; an add looks for the first
// entry of the same nonzero category and then replaces it, appends, or drops
// the item when the table is full. The result sits in an output register, so
// a new item is taken while it waits. Table contents need no clearing after
// reset; only the entry count is reset.
`default_nettype none

module pending_request_table_timeout_unit #(
  parameter int unsigned CAPACITY = prtt_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [prtt_pkg::AGE_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            kind_i,
  input  wire logic [prtt_pkg::ID_W-1:0]       request_id_i,
  input  wire logic [prtt_pkg::CATEGORY_W-1:0] proc_category_i,
  input  wire logic [prtt_pkg::HANDLER_W-1:0]  handler_tag_i,
  input  wire logic [prtt_pkg::TIME_W-1:0]     now_seconds_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [prtt_pkg::STATUS_W-1:0]        status_o,
  output logic [prtt_pkg::HANDLER_W-1:0]       handler_out_o
);
  import prtt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  prtt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .request_id_i    (request_id_i),
    .proc_category_i (proc_category_i),
    .handler_tag_i   (handler_tag_i),
    .now_seconds_i   (now_seconds_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .handler_out_o   (handler_out_o),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  prtt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

`default_nettype wire

// ----- hdl/prtt_mem.sv -----
// ----------------------------------------------------------------------------
// prtt_mem
// Entry table storage: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prtt_mem #(
  parameter int unsigned DEPTH = prtt_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(prtt_pkg::CAPACITY_DEF)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output prtt_pkg::entry_t      rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire prtt_pkg::entry_t wr_data_i
);
  import prtt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- hdl/prtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// prtt_ctrl
// Scan sequencer: walks the entry table once per item, matches, compacts on
// fetch, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prtt_ctrl #(
  parameter int unsigned CAPACITY = prtt_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(prtt_pkg::CAPACITY_DEF),
  parameter int unsigned CW       = $clog2(prtt_pkg::CAPACITY_DEF + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [prtt_pkg::AGE_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            kind_i,
  input  wire logic [prtt_pkg::ID_W-1:0]       request_id_i,
  input  wire logic [prtt_pkg::CATEGORY_W-1:0] proc_category_i,
  input  wire logic [prtt_pkg::HANDLER_W-1:0]  handler_tag_i,
  input  wire logic [prtt_pkg::TIME_W-1:0]     now_seconds_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [prtt_pkg::STATUS_W-1:0]        status_o,
  output logic [prtt_pkg::HANDLER_W-1:0]       handler_out_o,
  output logic                                 rd_en_o,
  output logic [AW-1:0]                        rd_addr_o,
  input  wire prtt_pkg::entry_t                rd_data_i,
  output logic                                 wr_en_o,
  output logic [AW-1:0]                        wr_addr_o,
  output prtt_pkg::entry_t                     wr_data_o
);
  import prtt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [AGE_W-1:0]      age_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         ridx_q;
  logic [CW-1:0]         widx_q;
  logic [AW-1:0]         pidx_q;
  logic [AW-1:0]         fidx_q;
  logic                  pend_q;
  logic                  found_q;
  logic [HANDLER_W-1:0]  hout_q;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [HANDLER_W-1:0]  handler_q;

  logic                  kind_q;
  logic [ID_W-1:0]       id_q;
  logic [CATEGORY_W-1:0] cat_q;
  logic [HANDLER_W-1:0]  tag_q;
  logic [TIME_W-1:0]     now_q;

  logic                  in_fire;
  logic                  has_room;
  logic                  out_free;
  logic [TIME_W-1:0]     age_diff;
  logic                  expired;
  logic                  id_hit;
  logic                  cat_hit;
  logic                  keep;
  logic                  add_write;
  status_e               status_new;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign has_room   = (count_q < CW'(CAPACITY));
  assign out_free   = !out_valid_q || out_ready_i;

  // modular age of the entry coming out of the memory
  assign age_diff = now_q - rd_data_i.stamp;
  assign expired  = (age_diff > {{(TIME_W-AGE_W){1'b0}}, age_q});
  assign id_hit   = !found_q && (rd_data_i.id == id_q);
  assign cat_hit  = !found_q && (cat_q != '0) && (rd_data_i.category == cat_q);
  // a fetch keeps an entry that is neither too old nor the first id match
  assign keep     = !expired && !id_hit;

  assign add_write = (state_q == S_DONE) && out_free && (kind_q == KIND_ADD) &&
                     (found_q || has_room);

  always_comb begin
    rd_en_o   = (state_q == S_SCAN) && (ridx_q < count_q);
    rd_addr_o = ridx_q[AW-1:0];
    if (state_q == S_SCAN) begin
      wr_en_o   = pend_q && (kind_q == KIND_FETCH) && keep;
      wr_addr_o = widx_q[AW-1:0];
      wr_data_o = rd_data_i;
    end else begin
      wr_en_o   = add_write;
      wr_addr_o = found_q ? fidx_q : count_q[AW-1:0];
      wr_data_o = '{id: id_q, category: cat_q, handler: tag_q, stamp: now_q};
    end
  end

  always_comb begin
    if (kind_q == KIND_ADD) begin
      if (found_q) begin
        status_new = ST_REPLACED;
      end else if (has_room) begin
        status_new = ST_APPENDED;
      end else begin
        status_new = ST_DROPPED;
      end
    end else begin
      status_new = found_q ? ST_HIT : ST_MISS;
    end
  end

  // item payload, held for the whole scan
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      id_q   <= request_id_i;
      cat_q  <= proc_category_i;
      tag_q  <= handler_tag_i;
      now_q  <= now_seconds_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      age_q       <= EXPIRE_AGE_RST;
      count_q     <= '0;
      ridx_q      <= '0;
      widx_q      <= '0;
      pidx_q      <= '0;
      fidx_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      hout_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      handler_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        age_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            ridx_q  <= '0;
            widx_q  <= '0;
            pend_q  <= 1'b0;
            found_q <= 1'b0;
            hout_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en_o) begin
            ridx_q <= ridx_q + CW'(1);
          end
          pend_q <= rd_en_o;
          pidx_q <= ridx_q[AW-1:0];
          if (pend_q) begin
            if (kind_q == KIND_ADD) begin
              if (cat_hit) begin
                found_q <= 1'b1;
                fidx_q  <= pidx_q;
              end
            end else if (!expired) begin
              if (id_hit) begin
                found_q <= 1'b1;
                hout_q  <= rd_data_i.handler;
              end else begin
                widx_q <= widx_q + CW'(1);
              end
            end
          end
          if (!rd_en_o && !pend_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            status_q    <= status_new;
            handler_q   <= hout_q;
            if (kind_q == KIND_FETCH) begin
              count_q <= widx_q;
            end else if (!found_q && has_room) begin
              count_q <= count_q + CW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign handler_out_o = handler_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_o && wr_en_o) |-> (rd_addr_o != wr_addr_o))
    else $error("read and write hit the same entry in one cycle");

  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> (widx_q <= CW'(pidx_q)))
    else $error("compaction write index passed the read index");

  a_fetch_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free && kind_q == KIND_FETCH) |=>
      (count_q <= $past(count_q)))
    else $error("fetch grew the table");

endmodule

`default_nettype wire
